// File: rtl/prr_pkg.sv
// prr_pkg: shared types, status codes and prefix mask helper
// for the prefix router; depends on nothing
package prr_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOMATCH  = 3'd1;
	localparam logic [2:0] ST_BADLEN   = 3'd2;
	localparam logic [2:0] ST_BADPORT  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_LISTFULL = 3'd5;

	// classified item handed from front to back
	typedef struct packed {
		logic       lookup;
		logic       dflt;
		logic [2:0] status;
		logic [1:0] cls;
		logic [31:0] addr;
		logic [7:0]  port;
	} item_t;

	// class 0 = /8, 1 = /16, 2 = /24, 3 = /32
	function automatic logic [31:0] class_mask(input logic [1:0] c);
		logic [31:0] m;
		unique case (c)
			2'd0: m = 32'hFF00_0000;
			2'd1: m = 32'hFFFF_0000;
			2'd2: m = 32'hFFFF_FF00;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/prefix_route_round_robin.sv
// prefix_route_round_robin: top level of the prefix router
// depends on prr_pkg, prr_front, prr_queue, prr_back
//
// usage
//   input channel: push/full; a beat carries kind (0 add route, 1 lookup),
//   address, pfx_len and route_port. full is high while the two-entry
//   queue between front and back holds two beats.
//   result channel: empty/pop; status, out_port and matched_len of the oldest
//   result stand while empty is low. every input beat gives one result beat.
// timing
//   the front classifies a beat as it is pushed (port check, length check,
//   prefix masking). the back scans the valid table entries one per cycle
//   through the entry memory read port, keeping the longest matching prefix
//   (lookup) or the equal prefix (add); then a decide step updates the table
//   and, for a lookup with a path, a port step reads the chosen path. the
//   next item is taken from the queue only once the result has been popped.
// reset
//   arst_n clears the table fill count, the default list count and pointer,
//   the queue and the result slot; memories need no clearing pass.
// stalls
//   while a result waits unpopped the back holds, the queue fills and full
//   rises; nothing is lost or repeated.
module prefix_route_round_robin #(
	parameter int ROUTE_ENTRIES = 64,
	parameter int MAX_PATHS     = 8,
	parameter int NUM_PORTS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [31:0] address,
	input  logic [5:0]  pfx_len,
	input  logic [7:0]  route_port,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [3:0]  out_port,
	output logic [5:0]  matched_len
);

	prr_pkg::item_t front_item;
	prr_pkg::item_t head_item;
	logic           q_vld;
	logic           q_pop;

	// classify the incoming beat
	prr_front #(.NUM_PORTS(NUM_PORTS)) u_front (
		.kind       (kind),
		.address    (address),
		.pfx_len    (pfx_len),
		.route_port (route_port),
		.item       (front_item)
	);

	// decouples the front from the table work
	prr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (full),
		.vld       (q_vld),
		.head      (head_item),
		.pop       (q_pop)
	);

	// table search, update and round-robin choice
	prr_back #(
		.ROUTE_ENTRIES (ROUTE_ENTRIES),
		.MAX_PATHS     (MAX_PATHS),
		.NUM_PORTS     (NUM_PORTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_vld       (q_vld),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.out_port    (out_port),
		.matched_len (matched_len)
	);

endmodule

// File: rtl/prr_front.sv
// prr_front: checks and classifies one input beat
// depends on prr_pkg
module prr_front #(
	parameter int NUM_PORTS = 16
) (
	input  logic             kind,
	input  logic [31:0]      address,
	input  logic [5:0]       pfx_len,
	input  logic [7:0]       route_port,
	output prr_pkg::item_t   item
);

	logic [1:0] cls;
	logic       len_ok;

	assign cls    = 2'(pfx_len[5:3] - 3'd1);
	assign len_ok = (pfx_len == 6'd8) || (pfx_len == 6'd16) ||
	                (pfx_len == 6'd24) || (pfx_len == 6'd32);

	always_comb begin
		item.lookup = kind;
		item.dflt   = 1'b0;
		item.status = prr_pkg::ST_OK;
		item.cls    = cls;
		item.addr   = address;
		item.port   = route_port;
		if (!kind) begin
			// port check wins over length check
			if ({1'b0, route_port} >= 9'(NUM_PORTS)) begin
				item.status = prr_pkg::ST_BADPORT;
			end else if (pfx_len == 6'd0) begin
				item.dflt = 1'b1;
			end else if (!len_ok) begin
				item.status = prr_pkg::ST_BADLEN;
			end else begin
				item.addr = address & prr_pkg::class_mask(cls);
			end
		end
	end

endmodule

// File: rtl/prr_queue.sv
// prr_queue: two-entry queue of classified items between front and back
// depends on prr_pkg
module prr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prr_pkg::item_t push_item,
	output logic           full,
	output logic           vld,
	output prr_pkg::item_t head,
	input  logic           pop
);

	prr_pkg::item_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign vld     = (cnt_q != 2'd0);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_item;
	end

endmodule

// File: rtl/prr_back.sv
// prr_back: table scan, path list update and round-robin pick
// depends on prr_pkg; owns the entry and path memories
module prr_back #(
	parameter int ROUTE_ENTRIES = 64,
	parameter int MAX_PATHS     = 8,
	parameter int NUM_PORTS     = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_vld,
	input  prr_pkg::item_t q_item,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic [2:0]     status,
	output logic [3:0]     out_port,
	output logic [5:0]     matched_len
);

	localparam int IDX_W   = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int ROW_W   = $clog2(ROUTE_ENTRIES + 1);
	localparam int SLOT_W  = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
	localparam int CNT_W   = $clog2(MAX_PATHS + 1);
	localparam int PDEPTH  = (ROUTE_ENTRIES + 1) * MAX_PATHS;
	localparam int PADDR_W = $clog2(PDEPTH);
	localparam int PORT_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_PORT   = 3'd4;

	typedef struct packed {
		logic [1:0]        cls;
		logic [31:0]       prefix;
		logic [CNT_W-1:0]  cnt;
		logic [SLOT_W-1:0] robin;
	} entry_t;

	entry_t             ent_mem [ROUTE_ENTRIES];
	logic [PORT_W-1:0]  pth_mem [PDEPTH];

	logic [2:0]         state_q;
	prr_pkg::item_t     item_q;
	logic [ROW_W-1:0]   fill_q, scan_idx_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	entry_t             ent_rd_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	entry_t             hit_ent_q;
	logic [CNT_W-1:0]   dflt_cnt_q;
	logic [SLOT_W-1:0]  dflt_robin_q;
	logic [5:0]         sel_len_q;
	logic [PORT_W-1:0]  pth_rd_q;
	logic               res_vld_q;
	logic [2:0]         status_q;
	logic [3:0]         out_port_q;
	logic [5:0]         matched_len_q;

	// decide-step controls
	logic               ent_we, pth_we;
	logic [IDX_W-1:0]   ent_waddr;
	entry_t             ent_wdata;
	logic [PADDR_W-1:0] pth_waddr, pth_raddr;
	logic [SLOT_W-1:0]  pick;
	logic [CNT_W-1:0]   pick_nxt;
	logic               cmp_hit;

	function automatic logic [PADDR_W-1:0] paddr(input logic [ROW_W-1:0] row,
	                                             input logic [SLOT_W-1:0] slot);
		return PADDR_W'(PADDR_W'(row) * PADDR_W'(MAX_PATHS) + PADDR_W'(slot));
	endfunction

	assign q_pop       = (state_q == S_IDLE) && q_vld && !res_vld_q;
	assign empty       = !res_vld_q;
	assign status      = status_q;
	assign out_port    = out_port_q;
	assign matched_len = matched_len_q;

	// compare of the entry read last cycle
	always_comb begin
		if (item_q.lookup) begin
			cmp_hit = ((item_q.addr & prr_pkg::class_mask(ent_rd_s1.cls)) ==
			           ent_rd_s1.prefix) && (!hit_q || ent_rd_s1.cls > hit_ent_q.cls);
		end else begin
			cmp_hit = (ent_rd_s1.cls == item_q.cls) && (ent_rd_s1.prefix == item_q.addr);
		end
	end

	// round-robin pick from the matching entry or the default list
	always_comb begin
		logic [CNT_W-1:0]  n;
		logic [SLOT_W-1:0] r;
		n = hit_q ? hit_ent_q.cnt : dflt_cnt_q;
		r = hit_q ? hit_ent_q.robin : dflt_robin_q;
		pick     = (CNT_W'(r) < n) ? r : '0;
		pick_nxt = (CNT_W'(pick) + CNT_W'(1) == n) ? '0 : CNT_W'(CNT_W'(pick) + CNT_W'(1));
	end

	always_comb begin
		ent_we    = 1'b0;
		pth_we    = 1'b0;
		ent_waddr = hit_idx_q;
		ent_wdata = hit_ent_q;
		pth_waddr = paddr(ROW_W'(hit_idx_q), hit_ent_q.cnt[SLOT_W-1:0]);
		pth_raddr = hit_q ? paddr(ROW_W'(hit_idx_q), pick)
		                  : paddr(ROW_W'(ROUTE_ENTRIES), pick);
		if (state_q == S_DECIDE) begin
			if (item_q.lookup) begin
				if (hit_q) begin
					ent_we          = 1'b1;
					ent_wdata.robin = SLOT_W'(pick_nxt);
				end
			end else if (item_q.dflt) begin
				pth_we    = (dflt_cnt_q < CNT_W'(MAX_PATHS));
				pth_waddr = paddr(ROW_W'(ROUTE_ENTRIES), dflt_cnt_q[SLOT_W-1:0]);
			end else if (hit_q) begin
				if (hit_ent_q.cnt < CNT_W'(MAX_PATHS)) begin
					ent_we        = 1'b1;
					ent_wdata.cnt = CNT_W'(hit_ent_q.cnt + CNT_W'(1));
					pth_we        = 1'b1;
				end
			end else if (fill_q != ROW_W'(ROUTE_ENTRIES)) begin
				ent_we           = 1'b1;
				ent_waddr        = fill_q[IDX_W-1:0];
				ent_wdata.cls    = item_q.cls;
				ent_wdata.prefix = item_q.addr;
				ent_wdata.cnt    = CNT_W'(1);
				ent_wdata.robin  = '0;
				pth_we           = 1'b1;
				pth_waddr        = paddr(fill_q, '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		ent_rd_s1  <= ent_mem[scan_idx_q[IDX_W-1:0]];
		cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (pth_we) pth_mem[pth_waddr] <= item_q.port[PORT_W-1:0];
		pth_rd_q <= pth_mem[pth_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (cmp_vld_s1 && cmp_hit) begin
			hit_idx_q <= cmp_idx_s1;
			hit_ent_q <= ent_rd_s1;
		end
		if (state_q == S_DECIDE) begin
			sel_len_q <= hit_q ? {3'({1'b0, hit_ent_q.cls}) + 3'd1, 3'b000} : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			scan_idx_q    <= '0;
			cmp_vld_s1    <= 1'b0;
			hit_q         <= 1'b0;
			dflt_cnt_q    <= '0;
			dflt_robin_q  <= '0;
			res_vld_q     <= 1'b0;
			status_q      <= prr_pkg::ST_OK;
			out_port_q    <= '0;
			matched_len_q <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
			if (cmp_vld_s1 && cmp_hit) hit_q <= 1'b1;
			if (pop && res_vld_q) res_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						hit_q      <= 1'b0;
						scan_idx_q <= '0;
						if (q_item.status != prr_pkg::ST_OK) begin
							res_vld_q     <= 1'b1;
							status_q      <= q_item.status;
							out_port_q    <= '0;
							matched_len_q <= '0;
						end else if (q_item.dflt || fill_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_idx_q == ROW_W'(fill_q - ROW_W'(1))) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= ROW_W'(scan_idx_q + ROW_W'(1));
					end
				end
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					out_port_q    <= '0;
					matched_len_q <= '0;
					status_q      <= prr_pkg::ST_OK;
					state_q       <= S_IDLE;
					if (item_q.lookup) begin
						if (hit_q) begin
							state_q <= S_PORT;
						end else if (dflt_cnt_q != '0) begin
							dflt_robin_q <= SLOT_W'(pick_nxt);
							state_q      <= S_PORT;
						end else begin
							res_vld_q <= 1'b1;
							status_q  <= prr_pkg::ST_NOMATCH;
						end
					end else begin
						res_vld_q <= 1'b1;
						if (item_q.dflt) begin
							if (dflt_cnt_q < CNT_W'(MAX_PATHS)) begin
								dflt_cnt_q <= CNT_W'(dflt_cnt_q + CNT_W'(1));
							end else begin
								status_q <= prr_pkg::ST_LISTFULL;
							end
						end else if (hit_q) begin
							if (hit_ent_q.cnt >= CNT_W'(MAX_PATHS)) begin
								status_q <= prr_pkg::ST_LISTFULL;
							end
						end else if (fill_q == ROW_W'(ROUTE_ENTRIES)) begin
							status_q <= prr_pkg::ST_FULL;
						end else begin
							fill_q <= ROW_W'(fill_q + ROW_W'(1));
						end
					end
				end
				S_PORT: begin
					res_vld_q     <= 1'b1;
					status_q      <= prr_pkg::ST_OK;
					out_port_q    <= 4'(pth_rd_q);
					matched_len_q <= sel_len_q;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result slot is free for the whole life of an item in work
	a_busy_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !res_vld_q) else $error("result slot busy during work");
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (fill_q != '0)) else $error("scan of empty table");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ROW_W'(ROUTE_ENTRIES)) else $error("fill count beyond table");
	a_dflt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dflt_cnt_q <= CNT_W'(MAX_PATHS)) else $error("default list overflow");

endmodule
